// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the cache datapath RTL. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES    = 4;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W     = IDX_W;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [CNT_W-1:0]      t_count;

    // Request function codes
    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_INSERT = 1'b1
    } t_func;

    // Controller state: result register empty or holding a beat
    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } t_ctrl_state;

    // Command from controller to datapath
    typedef struct packed {
        logic exec;
    } t_ctrl_cmd;

endpackage

// ===== rtl/lkvc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_req_if / lkvc_rsp_if
// Valid/ready channels for cache requests and results.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic                valid;
    logic                ready;
    logic                func;
    lkvc_pkg::t_key      key;
    lkvc_pkg::t_value    value_in;

    modport source (output valid, output func, output key, output value_in, input ready);
    modport sink   (input valid, input func, input key, input value_in, output ready);
endinterface

interface lkvc_rsp_if;
    logic                valid;
    logic                ready;
    logic                hit;
    lkvc_pkg::t_value    value_out;
    logic                evicted;

    modport source (output valid, output hit, output value_out, output evicted, input ready);
    modport sink   (input valid, input hit, input value_out, input evicted, output ready);
endinterface

// ===== rtl/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Handshake controller: tracks the result register and issues execute commands.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output lkvc_pkg::t_ctrl_cmd   o_cmd
);

    lkvc_pkg::t_ctrl_state r_state;
    lkvc_pkg::t_ctrl_state n_state;
    logic                  req_ready;
    logic                  exec;

    // Accept a request when the result slot is free or drains this cycle
    assign req_ready = (r_state == lkvc_pkg::ST_EMPTY) || i_rsp_ready;
    assign exec      = i_req_valid && req_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkvc_pkg::ST_EMPTY: begin
                if (exec) begin
                    n_state = lkvc_pkg::ST_FULL;
                end
            end
            lkvc_pkg::ST_FULL: begin
                if (i_rsp_ready && !exec) begin
                    n_state = lkvc_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_state = lkvc_pkg::ST_EMPTY;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready = req_ready;
        o_cmd.exec  = exec;
        case (r_state)
            lkvc_pkg::ST_FULL:  o_rsp_valid = 1'b1;
            lkvc_pkg::ST_EMPTY: o_rsp_valid = 1'b0;
            default:            o_rsp_valid = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/lkvc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_dpath
// Entry table, parallel key compare, recency update and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvc_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkvc_pkg::t_ctrl_cmd   i_cmd,
    input  logic                  i_func,
    input  lkvc_pkg::t_key        i_key,
    input  lkvc_pkg::t_value      i_value_in,
    output logic                  o_hit,
    output lkvc_pkg::t_value      o_value_out,
    output logic                  o_evicted
);

    localparam int N = lkvc_pkg::ENTRIES;

    lkvc_pkg::t_key     r_keys   [N];
    lkvc_pkg::t_key     n_keys   [N];
    lkvc_pkg::t_value   r_values [N];
    lkvc_pkg::t_value   n_values [N];
    lkvc_pkg::t_rank    r_rank   [N];
    lkvc_pkg::t_rank    n_rank   [N];
    logic [N-1:0]       r_valid;
    logic [N-1:0]       n_valid;
    lkvc_pkg::t_count   r_count;
    lkvc_pkg::t_count   n_count;
    logic               r_hit;
    logic               n_hit;
    lkvc_pkg::t_value   r_value_out;
    lkvc_pkg::t_value   n_value_out;
    logic               r_evicted;
    logic               n_evicted;

    logic               best_found;
    lkvc_pkg::t_idx     best_idx;
    lkvc_pkg::t_rank    best_rank;
    logic               free_found;
    lkvc_pkg::t_idx     free_idx;
    lkvc_pkg::t_idx     lru_idx;
    lkvc_pkg::t_idx     slot;
    logic               full;

    localparam lkvc_pkg::t_rank RANK_MAX = lkvc_pkg::RANK_W'(N - 1);

    // Find the most recent matching entry
    always_comb begin
        best_found = 1'b0;
        best_idx   = '0;
        best_rank  = '0;
        for (int i = 0; i < N; i++) begin
            if (r_valid[i] && (r_keys[i] == i_key) &&
                (!best_found || (r_rank[i] < best_rank))) begin
                best_found = 1'b1;
                best_idx   = lkvc_pkg::IDX_W'(i);
                best_rank  = r_rank[i];
            end
        end
    end

    // Find the lowest free slot and the least recent slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        lru_idx    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = lkvc_pkg::IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == RANK_MAX)) begin
                lru_idx = lkvc_pkg::IDX_W'(i);
            end
        end
    end

    assign full = (r_count == lkvc_pkg::CNT_W'(N)) || !free_found;
    assign slot = full ? lru_idx : free_idx;

    // Update table and load result on an executed request
    always_comb begin
        n_keys      = r_keys;
        n_values    = r_values;
        n_rank      = r_rank;
        n_valid     = r_valid;
        n_count     = r_count;
        n_hit       = r_hit;
        n_value_out = r_value_out;
        n_evicted   = r_evicted;
        if (i_cmd.exec) begin
            n_hit       = 1'b0;
            n_value_out = '0;
            n_evicted   = 1'b0;
            if (i_func == lkvc_pkg::FUNC_LOOKUP) begin
                if (best_found) begin
                    n_hit       = 1'b1;
                    n_value_out = r_values[best_idx];
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i] && (r_rank[i] < best_rank)) begin
                            n_rank[i] = r_rank[i] + 1'b1;
                        end
                    end
                    n_rank[best_idx] = '0;
                end
            end else begin
                // age every valid entry below the oldest rank, then place the new one as most recent
                for (int i = 0; i < N; i++) begin
                    if (r_valid[i] && (r_rank[i] < RANK_MAX)) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_keys[slot]   = i_key;
                n_values[slot] = i_value_in;
                n_valid[slot]  = 1'b1;
                n_rank[slot]   = '0;
                if (full) begin
                    n_evicted = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // Hold entry payload and results
    always_ff @(posedge i_clk) begin
        r_keys      <= n_keys;
        r_values    <= n_values;
        r_hit       <= n_hit;
        r_value_out <= n_value_out;
        r_evicted   <= n_evicted;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
        end
    end

    assign o_hit       = r_hit;
    assign o_value_out = r_value_out;
    assign o_evicted   = r_evicted;

    `ASSERT_ALWAYS(a_count_tracks_valid, i_clk, i_rst_n,
        lkvc_pkg::CNT_W'($countones(r_valid)) == r_count)
    `ASSERT_NEXT(a_insert_sets_valid, i_clk, i_rst_n,
        i_cmd.exec && (i_func == lkvc_pkg::FUNC_INSERT),
        r_valid[$past(slot)] && (r_rank[$past(slot)] == '0))
    `ASSERT_NEXT(a_evict_only_when_full, i_clk, i_rst_n,
        i_cmd.exec && (r_count != lkvc_pkg::CNT_W'(N)), !r_evicted)
    `ASSERT_NEXT(a_lookup_keeps_count, i_clk, i_rst_n,
        i_cmd.exec && (i_func == lkvc_pkg::FUNC_LOOKUP), $stable(r_count) && !r_evicted)

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one lookup or insert request per cycle and returns one result beat per
// request, in order, in the cycle after acceptance, from a result register. All
// ENTRIES keys are compared in parallel and the recency ranks are updated in
// the same cycle, so the rate is one request per clock while the result side
// keeps taking beats; a stalled result holds the request side until it drains.
// A lookup hit makes the matching entry most recent; an insert into a full
// table replaces the least recent entry and sets evicted.
module lru_key_value_cache_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkvc_req_if.sink    i_req,
    lkvc_rsp_if.source  o_rsp
);

    lkvc_pkg::t_ctrl_cmd cmd;

    // Handshake control
    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Entry table and result register
    lkvc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_req.func),
        .i_key       (i_req.key),
        .i_value_in  (i_req.value_in),
        .o_hit       (o_rsp.hit),
        .o_value_out (o_rsp.value_out),
        .o_evicted   (o_rsp.evicted)
    );

endmodule
